/* rtl/core/char_lcd_text_writer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the text writer top-level RTL
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_TEXT_WRITER_MACROS_SVH
`define CHAR_LCD_TEXT_WRITER_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define CLW_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("char_lcd_text_writer: check failed");

// Implication check: antecedent holds, consequent checked in the cycle after
`define CLW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("char_lcd_text_writer: sequencing check failed");

`endif

/* rtl/core/clw_pkg.sv */
// ----------------------------------------------------------------------------
// clw_pkg
// Types, codes and constants of the character LCD text writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clw_pkg;

  localparam int unsigned LINE_LENGTH_DEF = 16;

  typedef enum logic [2:0] {
    OP_CHAR    = 3'd0,
    OP_CURSOR  = 3'd1,
    OP_NEWLINE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_PRINT   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    BYTE_NONE   = 3'd0,
    BYTE_WRAP   = 3'd1,
    BYTE_CURSOR = 3'd2,
    BYTE_CLEAR  = 3'd3,
    BYTE_HOME   = 3'd4,
    BYTE_CHAR   = 3'd5
  } byte_e;

  localparam logic [1:0] LINE_SEL_ONE = 2'd1;
  localparam logic [1:0] LINE_SEL_TWO = 2'd2;

  localparam logic [7:0] ADDR_LINE_ONE = 8'h80;
  localparam logic [7:0] ADDR_LINE_TWO = 8'hC0;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;

  localparam logic [2:0] IDX_ONES = 3'd4;

  typedef struct packed {
    logic  load;
    logic  sub;
    logic  digit_done;
    logic  pend_minus;
    logic  pend_code;
    byte_e byte_sel;
    logic  emit_hi;
    logic  emit_lo;
  } clw_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       cursor_ok;
    logic       negative;
    logic       col_full;
    logic       ge;
    logic       digit_print;
    logic       byte_last;
    byte_e      byte_kind;
    logic       out_free;
  } clw_status_t;

  // Decimal weight of digit position, most significant first
  function automatic logic [13:0] pow10(input logic [2:0] idx);
    logic [13:0] w;
    case (idx)
      3'd0:    w = 14'd10000;
      3'd1:    w = 14'd1000;
      3'd2:    w = 14'd100;
      3'd3:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/char_lcd_text_writer.sv */
// ----------------------------------------------------------------------------
// char_lcd_text_writer
// Two-line character LCD writer over a 4-bit bus, one operation per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation per
//   transaction: write char, set cursor, new line, clear, print integer.
//   Output channel (out_valid_o/out_ready_i) carries one nibble per
//   transaction, high nibble of each byte first, with register_select_o;
//   last_o marks the final nibble of an item. Items with nothing to send
//   (unused codes, cursor out of range) produce no output transaction.
//   Sequence: the item is accepted, then decoded; each byte is selected
//   and then sent as high and low nibble. A character that would pass the
//   end of the line is preceded by the address byte of the other line.
//   Printing an integer adds the repeated-subtraction digit unit, which
//   subtracts each decimal weight until the rest is smaller, then selects
//   the digit byte; leading zeros are not printed.
//   If the receiver stalls, the current nibble holds in the output register
//   and the sequencer waits; the last nibble may wait while the next item
//   is accepted.
//   Reset puts the cursor at line one, column zero, and drops any pending
//   output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_text_writer_macros.svh"

module char_lcd_text_writer #(
  parameter int unsigned LINE_LENGTH = clw_pkg::LINE_LENGTH_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [2:0]         operation_i,
  input  wire  [7:0]         char_code_i,
  input  wire  [1:0]         line_select_i,
  input  wire  [7:0]         column_i,
  input  wire  signed [15:0] number_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [3:0]         nibble_o,
  output logic               register_select_o,
  output logic               last_o
);
  import clw_pkg::*;

  clw_cmd_t    cmd;
  clw_status_t status;

  clw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  clw_datapath #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .operation_i       (operation_i),
    .char_code_i       (char_code_i),
    .line_select_i     (line_select_i),
    .column_i          (column_i),
    .number_i          (number_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .nibble_o          (nibble_o),
    .register_select_o (register_select_o),
    .last_o            (last_o)
  );

  // An accepted item always keeps the sequencer busy for the next cycle
  `CLW_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // A nibble that is not the last one means its item is still in progress
  `CLW_ASSERT(a_not_last_busy, !(out_valid_o && !last_o && in_ready_o))
  // The sequencer only reads new input while idle, so no two loads overlap
  `CLW_ASSERT(a_load_only_idle, !cmd.load || in_ready_o)

endmodule

`default_nettype wire

/* rtl/core/clw_datapath.sv */
// ----------------------------------------------------------------------------
// clw_datapath
// Cursor state, digit extraction by repeated subtraction, byte and nibble
// output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clw_datapath #(
  parameter int unsigned LINE_LENGTH = clw_pkg::LINE_LENGTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  [2:0]          operation_i,
  input  wire  [7:0]          char_code_i,
  input  wire  [1:0]          line_select_i,
  input  wire  [7:0]          column_i,
  input  wire  signed [15:0]  number_i,
  input  clw_pkg::clw_cmd_t   cmd_i,
  output clw_pkg::clw_status_t status_o,
  input  wire                 out_ready_i,
  output logic                out_valid_o,
  output logic [3:0]          nibble_o,
  output logic                register_select_o,
  output logic                last_o
);
  import clw_pkg::*;

  localparam int unsigned ColW = $clog2(LINE_LENGTH + 1);

  logic [2:0]      op_q;
  logic [7:0]      code_q;
  logic [1:0]      lsel_q;
  logic [7:0]      colin_q;
  logic            neg_q;
  logic [15:0]     mag_q;
  logic [2:0]      idx_q;
  logic [3:0]      digit_q;
  logic            started_q;
  logic [7:0]      pend_q;
  logic            pend_last_q;
  logic [7:0]      byte_q;
  logic            byte_rs_q;
  logic            byte_last_q;
  byte_e           kind_q;
  logic            line_q;
  logic [ColW-1:0] col_q;
  logic            out_valid_q;
  logic [3:0]      nib_q;
  logic            rs_q;
  logic            last_q;

  logic [15:0] weight;
  logic        ge;
  logic        digit_print;
  logic        cursor_ok;
  logic        col_full;
  logic        out_free;

  assign weight      = {2'b00, pow10(idx_q)};
  assign ge          = (mag_q >= weight);
  assign digit_print = (digit_q != 4'd0) || started_q || (idx_q == IDX_ONES);
  assign cursor_ok   = ((lsel_q == LINE_SEL_ONE) || (lsel_q == LINE_SEL_TWO)) &&
                       (colin_q < 8'(LINE_LENGTH));
  assign col_full    = (col_q >= ColW'(LINE_LENGTH));
  assign out_free    = !out_valid_q || out_ready_i;

  // Capture the item and run the digit unit
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= operation_i;
      code_q    <= char_code_i;
      lsel_q    <= line_select_i;
      colin_q   <= column_i;
      neg_q     <= number_i[15];
      mag_q     <= number_i[15] ? (~number_i + 16'd1) : number_i;
      idx_q     <= 3'd0;
      digit_q   <= 4'd0;
      started_q <= 1'b0;
    end else if (cmd_i.sub) begin
      mag_q   <= mag_q - weight;
      digit_q <= digit_q + 4'd1;
    end else if (cmd_i.digit_done) begin
      if (digit_print) begin
        pend_q      <= CHAR_ZERO + {4'b0000, digit_q};
        pend_last_q <= (idx_q == IDX_ONES);
        started_q   <= 1'b1;
      end
      idx_q   <= idx_q + 3'd1;
      digit_q <= 4'd0;
    end
    if (cmd_i.pend_minus) begin
      pend_q      <= CHAR_MINUS;
      pend_last_q <= 1'b0;
    end else if (cmd_i.pend_code) begin
      pend_q      <= code_q;
      pend_last_q <= 1'b1;
    end
  end

  // Byte register
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_sel != BYTE_NONE) begin
      kind_q <= cmd_i.byte_sel;
    end
    case (cmd_i.byte_sel)
      BYTE_WRAP: begin
        byte_q      <= line_q ? ADDR_LINE_ONE : ADDR_LINE_TWO;
        byte_rs_q   <= 1'b0;
        byte_last_q <= (op_q == OP_NEWLINE);
      end
      BYTE_CURSOR: begin
        byte_q      <= ((lsel_q == LINE_SEL_ONE) ? ADDR_LINE_ONE : ADDR_LINE_TWO) + colin_q;
        byte_rs_q   <= 1'b0;
        byte_last_q <= 1'b1;
      end
      BYTE_CLEAR: begin
        byte_q      <= CMD_CLEAR;
        byte_rs_q   <= 1'b0;
        byte_last_q <= 1'b0;
      end
      BYTE_HOME: begin
        byte_q      <= CMD_HOME;
        byte_rs_q   <= 1'b0;
        byte_last_q <= 1'b1;
      end
      BYTE_CHAR: begin
        byte_q      <= pend_q;
        byte_rs_q   <= 1'b1;
        byte_last_q <= pend_last_q;
      end
      default: begin
      end
    endcase
  end

  // Cursor position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= 1'b0;
      col_q  <= '0;
    end else begin
      case (cmd_i.byte_sel)
        BYTE_WRAP: begin
          line_q <= ~line_q;
          col_q  <= '0;
        end
        BYTE_CURSOR: begin
          line_q <= (lsel_q == LINE_SEL_TWO);
          col_q  <= colin_q[ColW-1:0];
        end
        BYTE_CLEAR: begin
          line_q <= 1'b0;
          col_q  <= '0;
        end
        BYTE_CHAR: begin
          col_q <= col_q + ColW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: drop the transaction once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_hi || cmd_i.emit_lo) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_hi) begin
      nib_q  <= byte_q[7:4];
      rs_q   <= byte_rs_q;
      last_q <= 1'b0;
    end else if (cmd_i.emit_lo) begin
      nib_q  <= byte_q[3:0];
      rs_q   <= byte_rs_q;
      last_q <= byte_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign nibble_o          = nib_q;
  assign register_select_o = rs_q;
  assign last_o            = last_q;

  assign status_o.op          = op_q;
  assign status_o.cursor_ok   = cursor_ok;
  assign status_o.negative    = neg_q;
  assign status_o.col_full    = col_full;
  assign status_o.ge          = ge;
  assign status_o.digit_print = digit_print;
  assign status_o.byte_last   = byte_last_q;
  assign status_o.byte_kind   = kind_q;
  assign status_o.out_free    = out_free;

endmodule

`default_nettype wire

/* rtl/core/clw_ctrl.sv */
// ----------------------------------------------------------------------------
// clw_ctrl
// Sequencer: decodes the operation and steps the datapath byte by byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clw_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  clw_pkg::clw_status_t status_i,
  output clw_pkg::clw_cmd_t    cmd_o
);
  import clw_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DISPATCH = 7'b0000010,
    ST_CHAR     = 7'b0000100,
    ST_DIGIT    = 7'b0001000,
    ST_HOME     = 7'b0010000,
    ST_SEND_HI  = 7'b0100000,
    ST_SEND_LO  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.byte_sel = BYTE_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.op)
          OP_CHAR: begin
            cmd_o.pend_code = 1'b1;
            state_d         = ST_CHAR;
          end
          OP_CURSOR: begin
            if (status_i.cursor_ok) begin
              cmd_o.byte_sel = BYTE_CURSOR;
              state_d        = ST_SEND_HI;
            end else begin
              state_d = ST_IDLE;
            end
          end
          OP_NEWLINE: begin
            cmd_o.byte_sel = BYTE_WRAP;
            state_d        = ST_SEND_HI;
          end
          OP_CLEAR: begin
            cmd_o.byte_sel = BYTE_CLEAR;
            state_d        = ST_SEND_HI;
          end
          OP_PRINT: begin
            if (status_i.negative) begin
              cmd_o.pend_minus = 1'b1;
              state_d          = ST_CHAR;
            end else begin
              state_d = ST_DIGIT;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_CHAR: begin
        // Wrap to the other line before a character past the end
        cmd_o.byte_sel = status_i.col_full ? BYTE_WRAP : BYTE_CHAR;
        state_d        = ST_SEND_HI;
      end
      ST_DIGIT: begin
        if (status_i.ge) begin
          cmd_o.sub = 1'b1;
        end else begin
          cmd_o.digit_done = 1'b1;
          if (status_i.digit_print) begin
            state_d = ST_CHAR;
          end
        end
      end
      ST_HOME: begin
        cmd_o.byte_sel = BYTE_HOME;
        state_d        = ST_SEND_HI;
      end
      ST_SEND_HI: begin
        if (status_i.out_free) begin
          cmd_o.emit_hi = 1'b1;
          state_d       = ST_SEND_LO;
        end
      end
      ST_SEND_LO: begin
        if (status_i.out_free) begin
          cmd_o.emit_lo = 1'b1;
          if (status_i.byte_last) begin
            state_d = ST_IDLE;
          end else begin
            case (status_i.byte_kind)
              BYTE_WRAP:  state_d = ST_CHAR;
              BYTE_CLEAR: state_d = ST_HOME;
              BYTE_CHAR:  state_d = ST_DIGIT;
              default:    state_d = ST_IDLE;
            endcase
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
